/* hw/rtl/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants of the slewed tick clock
// Opcodes, tick rate limits and the width of the uptime word.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned RATE_W = 16;

	typedef logic [1:0] opcode_t;

	localparam opcode_t OP_TICK      = 2'd0;
	localparam opcode_t OP_SET_WALL  = 2'd1;
	localparam opcode_t OP_LOAD_SLEW = 2'd2;

	localparam logic [RATE_W-1:0] RATE_DEFAULT = 16'd60;
	localparam logic [RATE_W-1:0] RATE_MIN     = 16'd2;
	localparam logic [RATE_W-1:0] RATE_MAX     = 16'd50000;

	// handshake between the top level and the serial divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* hw/rtl/stc_divmod.sv */
// ----------------------------------------------------------------------------
// stc_divmod: bit-serial divide with folded modulo
// Restoring division of the uptime by (rate * unit seconds), one quotient
// bit per cycle, MSB first; each quotient bit is folded into a running
// remainder modulo the history length, so no quotient word is kept.
// ----------------------------------------------------------------------------
module stc_divmod
	import stc_pkg::*;
#(
	parameter int DIV_W  = 22,
	parameter int LEN    = 64,
	parameter int SLOT_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [DIV_W-1:0]  divisor,
	output div_stat_t         stat,
	output logic [SLOT_W-1:0] slot
);

	localparam int CNT_W = $clog2(TIME_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);
	localparam logic [SLOT_W:0]  LEN_V    = (SLOT_W+1)'(LEN);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] dvd_q;
	logic [DIV_W-1:0]  rem_q;
	logic [SLOT_W-1:0] mod_q;

	logic [DIV_W:0]    trial;
	logic              qbit;
	logic [DIV_W:0]    rem_diff;
	logic [DIV_W-1:0]  rem_n;
	logic [SLOT_W:0]   mod_trial;
	logic [SLOT_W-1:0] mod_n;

	always_comb begin
		trial     = {rem_q, dvd_q[TIME_W-1]};
		qbit      = (trial >= {1'b0, divisor});
		rem_diff  = trial - {1'b0, divisor};
		rem_n     = qbit ? rem_diff[DIV_W-1:0] : trial[DIV_W-1:0];
		mod_trial = {mod_q, qbit};
		// mod_q < LEN, so one conditional subtract keeps it reduced
		if (mod_trial >= LEN_V) begin
			mod_trial = mod_trial - LEN_V;
		end
		mod_n = mod_trial[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start && !busy_q) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			rem_q <= '0;
			mod_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			rem_q <= rem_n;
			mod_q <= mod_n;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == CNT_LAST);
	assign slot      = mod_n;

endmodule

/* hw/rtl/system_tick_clock_with_slew_and_load_top.sv */
// ----------------------------------------------------------------------------
// system_tick_clock_with_slew_and_load_top: slewed tick clock, load history
// Uptime and wall clock with slew, plus a per-slot ready-process sum.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one item per operation. opcode
//   selects a tick (uses ready_count), a wall time set (new_wall_time) or a
//   slew load (slew_ticks). Unused opcodes only report the state.
//   Output channel (out_valid / out_stall): one result item per input item,
//   giving uptime, wall time, remaining slew, current load slot and its sum.
//   Config channel (cfg_valid / cfg_ready / cfg_data): tick rate in Hz; out of
//   range values (below 2 or above 50000) fall back to 60. Write while idle.
// Timing
//   A tick's slot is uptime / (rate * unit seconds) mod history length, from a
//   serial divider giving one quotient bit per cycle; when it is done the
//   result goes to the push step, and other opcodes go there directly. in_stall
//   is high while in work, until the push step hands the result on.
// Reset
//   All counters, slew, slot and sum clear; rate returns to 60. A held result
//   stays on the output while out_stall is high; the block takes the next
//   item meanwhile but cannot publish it until the output register frees.
// Only the current slot's sum is ever reported and a slot is cleared when it
// is entered, so the history collapses to one running sum register.
// ----------------------------------------------------------------------------
module system_tick_clock_with_slew_and_load_top
	import stc_pkg::*;
#(
	parameter int LOAD_HISTORY_LEN  = 64,
	parameter int LOAD_UNIT_SECONDS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [RATE_W-1:0]  cfg_data,
	// input items
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [31:0]        new_wall_time,
	input  logic signed [31:0] slew_ticks,
	input  logic [15:0]        ready_count,
	// result items
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        uptime_ticks,
	output logic [31:0]        wall_ticks,
	output logic signed [31:0] slew_left,
	output logic [9:0]         load_slot,
	output logic [31:0]        slot_load_sum
);

	localparam int DIV_W  = RATE_W + $clog2(LOAD_UNIT_SECONDS + 1);
	localparam int SLOT_W = $clog2(LOAD_HISTORY_LEN);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	localparam logic [DIV_W-1:0] UNIT_V    = DIV_W'(LOAD_UNIT_SECONDS);
	localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(RATE_DEFAULT) * UNIT_V;

	logic [1:0]        state_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [TIME_W-1:0] uptime_q;
	logic [TIME_W-1:0] wall_q;
	logic [TIME_W-1:0] slew_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TIME_W-1:0] sum_q;
	logic [15:0]       ready_q;

	logic              out_valid_q;
	logic [TIME_W-1:0] out_uptime_q;
	logic [TIME_W-1:0] out_wall_q;
	logic [TIME_W-1:0] out_slew_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [TIME_W-1:0] out_sum_q;

	logic              in_take;
	logic              out_free;
	logic              div_start;
	logic [TIME_W-1:0] uptime_inc;
	logic [RATE_W-1:0] rate_clamped;
	div_stat_t         div_stat;
	logic [SLOT_W-1:0] div_slot;

	assign in_take   = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign div_start = in_take && (opcode == OP_TICK);
	assign uptime_inc = uptime_q + 1'b1;

	always_comb begin
		if (cfg_data inside {[RATE_MIN:RATE_MAX]}) begin
			rate_clamped = cfg_data;
		end else begin
			rate_clamped = RATE_DEFAULT;
		end
	end

	// rate * unit seconds, kept ready for the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= DIV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			divisor_q <= DIV_W'(rate_clamped) * UNIT_V;
		end
	end

	stc_divmod #(
		.DIV_W  (DIV_W),
		.LEN    (LOAD_HISTORY_LEN),
		.SLOT_W (SLOT_W)
	) u_divmod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (uptime_inc),
		.divisor  (divisor_q),
		.stat     (div_stat),
		.slot     (div_slot)
	);

	// sequencer and clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			uptime_q <= '0;
			wall_q   <= '0;
			slew_q   <= '0;
			slot_q   <= '0;
			sum_q    <= '0;
			ready_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						case (opcode)
							OP_TICK: begin
								state_q  <= ST_DIV;
								uptime_q <= uptime_inc;
								ready_q  <= ready_count;
								// slew acts on odd uptime only
								if ((slew_q != '0) && uptime_inc[0]) begin
									if (!slew_q[TIME_W-1]) begin
										wall_q <= wall_q + 32'd2;
										slew_q <= slew_q - 1'b1;
									end else begin
										slew_q <= slew_q + 1'b1;
									end
								end else begin
									wall_q <= wall_q + 1'b1;
								end
							end
							OP_SET_WALL: begin
								state_q <= ST_PUSH;
								wall_q  <= new_wall_time;
							end
							OP_LOAD_SLEW: begin
								state_q <= ST_PUSH;
								slew_q  <= slew_ticks;
							end
							default: begin
								state_q <= ST_PUSH;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_PUSH;
						slot_q  <= div_slot;
						// entering a new slot clears its entry first
						if (div_slot != slot_q) begin
							sum_q <= TIME_W'(ready_q);
						end else begin
							sum_q <= sum_q + TIME_W'(ready_q);
						end
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_PUSH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_PUSH) && out_free) begin
			out_uptime_q <= uptime_q;
			out_wall_q   <= wall_q;
			out_slew_q   <= slew_q;
			out_slot_q   <= slot_q;
			out_sum_q    <= sum_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign uptime_ticks  = out_uptime_q;
	assign wall_ticks    = out_wall_q;
	assign slew_left     = out_slew_q;
	assign load_slot     = 10'(out_slot_q);
	assign slot_load_sum = out_sum_q;

endmodule

/* tb/system_tick_clock_with_slew_and_load_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// system_tick_clock_with_slew_and_load_top_tb: self-checking bench
// Sends tick, wall set, slew load and unused opcodes over the valid/stall
// input channel. The bench keeps its own copy of uptime, wall time, slew and
// load history, predicts one result per accepted item, and compares every
// result item field by field in order. Both sides idle at random. The tick
// rate register is rewritten between phases.
// ----------------------------------------------------------------------------
module system_tick_clock_with_slew_and_load_top_tb;
	import stc_pkg::*;

	localparam int unsigned HIST_LEN = 64;
	localparam int unsigned UNIT_SEC = 6;
	// opcode 3 has no meaning in the block, it only reports the state
	localparam opcode_t OP_UNUSED = 2'd3;
	// longer than a tick takes in the block, to give it some margin
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_REPORTS = 10;
	localparam int IDLE_PCT = 31;
	localparam int HOLD_CYCLES = 300;

	// one result item as the block reports it
	typedef struct packed {
		logic [31:0] uptime;
		logic [31:0] wall;
		logic [31:0] slew;
		logic [9:0]  slot;
		logic [31:0] sum;
	} clock_readout_t;

	// DUT connections; every input is driven to a known value from time zero
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [RATE_W-1:0]  cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	opcode_t            opcode = OP_TICK;
	logic [31:0]        new_wall_time = '0;
	logic signed [31:0] slew_ticks = '0;
	logic [15:0]        ready_count = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [31:0]        uptime_ticks;
	logic [31:0]        wall_ticks;
	logic signed [31:0] slew_left;
	logic [9:0]         load_slot;
	logic [31:0]        slot_load_sum;

	// bench copy of the clock state
	logic [31:0]        clk_uptime;
	logic [31:0]        clk_wall;
	logic [31:0]        clk_slew;
	int unsigned        cur_slot;
	logic [31:0]        load_hist [HIST_LEN];
	logic [RATE_W-1:0]  tick_rate;

	clock_readout_t     expected_readouts [$];
	int                 mismatches = 0;

	// idle controls; the enables change only at a rising edge, read at a falling one
	bit                 tx_idle_en = 1'b1;
	bit                 rx_idle_en = 1'b1;
	int                 hold_left = 0;

	system_tick_clock_with_slew_and_load_top #(
		.LOAD_HISTORY_LEN (HIST_LEN),
		.LOAD_UNIT_SECONDS(UNIT_SEC)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.new_wall_time(new_wall_time),
		.slew_ticks   (slew_ticks),
		.ready_count  (ready_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.uptime_ticks (uptime_ticks),
		.wall_ticks   (wall_ticks),
		.slew_left    (slew_left),
		.load_slot    (load_slot),
		.slot_load_sum(slot_load_sum)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one operation to the bench state and return the result the block
	// must report. Slew only acts on ticks that make the uptime odd: a
	// positive count doubles the wall step, a negative one skips it.
	function automatic clock_readout_t apply_clock_op(opcode_t op, logic [31:0] wall_in,
			logic [31:0] slew_in, logic [15:0] ready);
		int unsigned    slot;
		clock_readout_t r;
		case (op)
			OP_TICK: begin
				clk_uptime = clk_uptime + 32'd1;
				if (clk_slew != 32'd0 && clk_uptime[0]) begin
					if (!clk_slew[31]) begin
						clk_wall = clk_wall + 32'd2;
						clk_slew = clk_slew - 32'd1;
					end else begin
						clk_slew = clk_slew + 32'd1;
					end
				end else begin
					clk_wall = clk_wall + 32'd1;
				end
				slot = (clk_uptime / tick_rate / UNIT_SEC) % HIST_LEN;
				// entering a new slot starts its sum from zero
				if (slot != cur_slot) begin
					load_hist[slot] = 32'd0;
					cur_slot = slot;
				end
				load_hist[slot] = load_hist[slot] + ready;
			end
			OP_SET_WALL:  clk_wall = wall_in;
			OP_LOAD_SLEW: clk_slew = slew_in;
			default: ;
		endcase
		r.uptime = clk_uptime;
		r.wall   = clk_wall;
		r.slew   = clk_slew;
		r.slot   = cur_slot[9:0];
		r.sum    = load_hist[cur_slot];
		return r;
	endfunction

	// Offer one item, hold it until accepted, queue its prediction.
	// Entered and left at a falling edge with in_valid low.
	task automatic send_item(opcode_t op, logic [31:0] wall_v, logic [31:0] slew_v,
			logic [15:0] ready_v);
		if (tx_idle_en && $urandom_range(99) < IDLE_PCT)
			repeat ($urandom_range(1, 4)) @(negedge clk);
		in_valid      = 1'b1;
		opcode        = op;
		new_wall_time = wall_v;
		slew_ticks    = slew_v;
		ready_count   = ready_v;
		do @(posedge clk); while (in_stall);
		expected_readouts.push_back(apply_clock_op(op, wall_v, slew_v, ready_v));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Mostly ticks; slew loads are small counts half the time so they run
	// out and the slew-to-zero transition is seen often.
	task automatic send_random_item(int tick_pct);
		int          pick;
		opcode_t     op;
		logic [31:0] slew_v;
		pick   = $urandom_range(99);
		slew_v = $urandom;
		if ($urandom_range(1)) begin
			slew_v = $urandom_range(1, 6);
			if ($urandom_range(1))
				slew_v = -slew_v;
		end
		if (pick < tick_pct)
			op = OP_TICK;
		else if (pick < tick_pct + 7)
			op = OP_SET_WALL;
		else if (pick < tick_pct + 14)
			op = OP_LOAD_SLEW;
		else
			op = OP_UNUSED;
		send_item(op, $urandom, slew_v, 16'($urandom));
	endtask

	// wait until every result is in, then let the block settle
	task automatic wait_idle();
		while (expected_readouts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// rate writes happen only with the block idle; bad rates fall back to 60
	task automatic write_rate(logic [RATE_W-1:0] rate_v);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_data  = rate_v;
		do @(posedge clk); while (!cfg_ready);
		tick_rate = (rate_v < RATE_MIN || rate_v > RATE_MAX) ? RATE_DEFAULT : rate_v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_idling(bit tx_en, bit rx_en);
		@(posedge clk);
		tx_idle_en = tx_en;
		rx_idle_en = rx_en;
		@(negedge clk);
	endtask

	// Output side stall. A hold request keeps the output stalled until hold_left
	// counts down to zero; otherwise stall at random when enabled.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall = 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall = rx_idle_en && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Result checker: every accepted result against the oldest prediction.
	always @(posedge clk) begin : check_results
		clock_readout_t got;
		clock_readout_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {uptime_ticks, wall_ticks, slew_left, load_slot, slot_load_sum};
			if (expected_readouts.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result item with none expected: up=%h wall=%h slew=%h slot=%0d sum=%h",
						$time, got.uptime, got.wall, got.slew, got.slot, got.sum);
			end else begin
				want = expected_readouts.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: result item differs", $time);
						$display("  expected up=%h wall=%h slew=%h slot=%0d sum=%h",
							want.uptime, want.wall, want.slew, want.slot, want.sum);
						$display("  actual   up=%h wall=%h slew=%h slot=%0d sum=%h",
							got.uptime, got.wall, got.slew, got.slot, got.sum);
					end
				end
			end
		end
	end

	// Field extremes, every opcode, wall wrap, slew of both signs running
	// out, the largest slew magnitudes, and the unused opcode.
	task automatic test_directed_ops();
		send_item(OP_UNUSED, '1, '1, '1);
		send_item(OP_TICK, '0, '0, 16'hFFFF);
		send_item(OP_TICK, '1, '1, 16'h0000);
		send_item(OP_SET_WALL, 32'hFFFF_FFFF, '0, '0);
		send_item(OP_TICK, '0, '0, 16'hFFFF);      // wall wraps to zero
		send_item(OP_SET_WALL, 32'h0000_0000, '1, '1);
		send_item(OP_LOAD_SLEW, '0, 32'd1, '0);
		send_item(OP_TICK, '0, '0, 16'd1);         // even uptime, plain step
		send_item(OP_TICK, '0, '0, 16'd2);         // odd uptime, double step
		send_item(OP_LOAD_SLEW, '0, -32'sd1, '0);
		send_item(OP_TICK, '0, '0, 16'd3);
		send_item(OP_TICK, '0, '0, 16'd4);         // odd uptime, wall holds
		send_item(OP_LOAD_SLEW, '0, 32'h7FFF_FFFF, '0);
		send_item(OP_TICK, '0, '0, 16'hFFFF);
		send_item(OP_TICK, '0, '0, 16'hFFFF);
		send_item(OP_LOAD_SLEW, '0, 32'h8000_0000, '0);
		send_item(OP_TICK, '0, '0, 16'h5555);
		send_item(OP_TICK, '0, '0, 16'hAAAA);
		send_item(OP_LOAD_SLEW, '0, 32'd0, '0);
		send_item(OP_SET_WALL, 32'hA5A5_5A5A, '0, '0);
		send_item(OP_UNUSED, '0, '0, '0);
		send_item(OP_TICK, '0, '0, 16'hFFFF);
	endtask

	// Every kind of rate write: zero, one, the limits, just above the top,
	// all ones, and a tiny legal rate; ticks after each to move the slot.
	task automatic test_rate_register();
		logic [RATE_W-1:0] rates [8];
		rates = '{16'd0, 16'd1, RATE_MIN, RATE_MAX, 16'd50001, 16'hFFFF, 16'd3,
			RATE_DEFAULT};
		foreach (rates[i]) begin
			write_rate(rates[i]);
			repeat (20) send_random_item(85);
		end
	endtask

	// Output held off for a long stretch while the input keeps offering
	// items back to back: the block fills and must stall its input.
	task automatic test_output_holdoff();
		set_idling(1'b0, 1'b0);
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		@(negedge clk);
		repeat (16) send_random_item(80);
		set_idling(1'b1, 1'b1);
	endtask

	// Bulk random traffic. The smallest rate makes the slot move every 12
	// ticks, so the 64-entry history wraps within the first phase.
	task automatic test_random_traffic();
		write_rate(RATE_MIN);
		repeat (900) send_random_item(80);
		// a stretch with neither side idling
		set_idling(1'b0, 1'b0);
		repeat (200) send_random_item(80);
		set_idling(1'b1, 1'b1);
		write_rate(16'($urandom_range(2, 12)));
		repeat (150) send_random_item(75);
		write_rate(16'($urandom));
		repeat (100) send_random_item(75);
	endtask

	initial begin
		tick_rate  = RATE_DEFAULT;
		clk_uptime = '0;
		clk_wall   = '0;
		clk_slew   = '0;
		cur_slot   = 0;
		foreach (load_hist[i])
			load_hist[i] = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_ops();
		test_rate_register();
		test_output_holdoff();
		test_random_traffic();

		wait_idle();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// timeout, far beyond a correct run
	initial begin
		#12_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
